/* src/drt_pkg.sv */
// ----------------------------------------------------------------------------
// Difficulty retarget package
// Shared constants, register indexes and beat types of the retarget core.
// ----------------------------------------------------------------------------
`default_nettype none

package drt_pkg;

   localparam int WORD_BITS = 256;
   localparam int LIMB_BITS = 32;
   localparam int LIMBS = WORD_BITS / LIMB_BITS;
   localparam int INTERVAL_BITS = 24;
   localparam int SPAN_BITS = 25;
   localparam int DIV_STEPS_DEFAULT = 8;

   // Damping and clamp constants.
   localparam logic [6:0] LOW_PERCENT = 7'd84;
   localparam logic [7:0] HIGH_PERCENT = 8'd132;
   localparam logic [1:0] OLD_WEIGHT = 2'd3;
   // Reciprocal of one hundred, exact for every product below 2^32.
   localparam logic [31:0] RECIP_HUNDRED = 32'd2748779070;
   localparam int RECIP_SHIFT = 38;

   // Register indexes.
   localparam logic [2:0] CSR_INTERVAL = 3'd0;
   localparam logic [2:0] CSR_LIMIT3 = 3'd1;
   localparam logic [2:0] CSR_LIMIT2 = 3'd2;
   localparam logic [2:0] CSR_LIMIT1 = 3'd3;
   localparam logic [2:0] CSR_LIMIT0 = 3'd4;

   localparam logic [23:0] INTERVAL_RESET = 24'd15000;
   localparam logic [63:0] LIMIT3_RESET = 64'h00ff_ffff_ffff_ffff;
   localparam logic [63:0] LIMIT_LOW_RESET = 64'hffff_ffff_ffff_ffff;

   typedef struct packed {
      logic [WORD_BITS-1:0] word;
      logic [INTERVAL_BITS-1:0] rem;
      logic [SPAN_BITS-1:0] span;
   } div_beat_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] word;
      logic [SPAN_BITS-1:0] carry;
      logic [SPAN_BITS-1:0] span;
   } mul_beat_type;

endpackage

`default_nettype wire

/* src/drt_div_cell.sv */
// ----------------------------------------------------------------------------
// Divider cell
// Takes STEPS restoring division steps on each beat it takes in and hands it on.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_div_cell #(
   parameter int STEPS = drt_pkg::DIV_STEPS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [drt_pkg::INTERVAL_BITS-1:0]  divisor,
   input  wire logic                               in_valid,
   output logic                                    in_ready,
   input  wire drt_pkg::div_beat_type              in_data,
   output logic                                    out_valid,
   input  wire logic                               out_ready,
   output drt_pkg::div_beat_type                   out_data
);
   import drt_pkg::*;

   logic valid_ff;
   div_beat_type data_ff, data_in;

   // The dividend leaves the word at the top while quotient bits enter at
   // the bottom, so the word holds the quotient after the last cell.
   always_comb begin
      logic [INTERVAL_BITS:0] trial;
      logic [WORD_BITS-1:0] w;
      logic [INTERVAL_BITS-1:0] r;
      w = in_data.word;
      r = in_data.rem;
      trial = '0;
      for (int k = 0; k < STEPS; k++) begin
         trial = {r, w[WORD_BITS-1]};
         w = {w[WORD_BITS-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            trial = trial - {1'b0, divisor};
            w[0] = 1'b1;
         end
         r = trial[INTERVAL_BITS-1:0];
      end
      data_in.word = w;
      data_in.rem = r;
      data_in.span = in_data.span;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

`default_nettype wire

/* src/drt_mul_cell.sv */
// ----------------------------------------------------------------------------
// Multiplier cell
// Multiplies one 32-bit limb by the span and passes the carry to the next.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_mul_cell #(
   parameter int LIMB = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire drt_pkg::mul_beat_type in_data,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output drt_pkg::mul_beat_type      out_data
);
   import drt_pkg::*;

   logic valid_ff;
   mul_beat_type data_ff, data_in;
   logic [LIMB_BITS+SPAN_BITS-1:0] product;

   always_comb begin
      product = in_data.word[LIMB*LIMB_BITS +: LIMB_BITS] * in_data.span
              + {{LIMB_BITS{1'b0}}, in_data.carry};
      data_in = in_data;
      data_in.word[LIMB*LIMB_BITS +: LIMB_BITS] = product[LIMB_BITS-1:0];
      data_in.carry = product[LIMB_BITS +: SPAN_BITS];
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;

endmodule

`default_nettype wire

/* src/drt_encode.sv */
// ----------------------------------------------------------------------------
// Limit clamp and compact encoder
// Clamps the new target to the limit and packs it into compact form.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_encode (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [drt_pkg::WORD_BITS-1:0] limit,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic [drt_pkg::WORD_BITS-1:0] in_word,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [31:0]                        out_compact
);
   import drt_pkg::*;

   logic c_valid_ff, l_valid_ff, s_valid_ff, o_valid_ff;
   logic c_ready, l_ready, s_ready, o_ready;
   logic [WORD_BITS-1:0] c_word_ff, l_word_ff, s_word_ff;
   logic [LIMBS-1:0] l_nz_ff, l_nz_in;
   logic [LIMBS-1:0][4:0] l_pos_ff, l_pos_in;
   logic [5:0] s_size_ff, s_size_in;
   logic [31:0] o_compact_ff, o_compact_in;

   assign o_ready = !o_valid_ff || out_ready;
   assign s_ready = !s_valid_ff || o_ready;
   assign l_ready = !l_valid_ff || s_ready;
   assign c_ready = !c_valid_ff || l_ready;
   assign in_ready = c_ready;

   // Leading one of every limb.
   always_comb begin
      for (int i = 0; i < LIMBS; i++) begin
         l_nz_in[i] = |c_word_ff[i*LIMB_BITS +: LIMB_BITS];
         l_pos_in[i] = '0;
         for (int b = 0; b < LIMB_BITS; b++) begin
            if (c_word_ff[i*LIMB_BITS + b]) begin
               l_pos_in[i] = 5'(b);
            end
         end
      end
   end

   always_comb begin
      logic [8:0] bit_len;
      logic [9:0] rounded;
      bit_len = '0;
      for (int i = 0; i < LIMBS; i++) begin
         if (l_nz_ff[i]) begin
            bit_len = {3'(i), l_pos_ff[i]} + 9'd1;
         end
      end
      rounded = {1'b0, bit_len} + 10'd7;
      s_size_in = rounded[8:3];
   end

   always_comb begin
      logic [23:0] mant;
      logic [6:0] size;
      logic [1:0] lsh;
      logic [4:0] rsh;
      logic [WORD_BITS-1:0] shifted;
      size = {1'b0, s_size_ff};
      lsh = '0;
      rsh = '0;
      shifted = '0;
      if (s_size_ff <= 6'd3) begin
         lsh = 2'(6'd3 - s_size_ff);
         mant = s_word_ff[23:0] << {lsh, 3'b000};
      end else begin
         rsh = 5'(s_size_ff - 6'd3);
         shifted = s_word_ff >> {rsh, 3'b000};
         mant = shifted[23:0];
      end
      // A mantissa with its top bit set would read as negative.
      if (mant[23]) begin
         mant = {8'd0, mant[23:8]};
         size = size + 7'd1;
      end
      o_compact_in = {1'b0, size, 1'b0, mant[22:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         l_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (c_ready) c_valid_ff <= in_valid;
         if (l_ready) l_valid_ff <= c_valid_ff;
         if (s_ready) s_valid_ff <= l_valid_ff;
         if (o_ready) o_valid_ff <= s_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_ready && in_valid) begin
         c_word_ff <= (in_word > limit) ? limit : in_word;
      end
      if (l_ready && c_valid_ff) begin
         l_word_ff <= c_word_ff;
         l_nz_ff <= l_nz_in;
         l_pos_ff <= l_pos_in;
      end
      if (s_ready && l_valid_ff) begin
         s_word_ff <= l_word_ff;
         s_size_ff <= s_size_in;
      end
      if (o_ready && s_valid_ff) begin
         o_compact_ff <= o_compact_in;
      end
   end

   assign out_valid = o_valid_ff;
   assign out_compact = o_compact_ff;

endmodule

`default_nettype wire

/* src/difficulty_retarget_core.sv */
// ----------------------------------------------------------------------------
// Difficulty retarget core
// Damped retarget of a compact difficulty through a divider and multiplier
// chain of cells.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while the output is not stalled; every
// cell of the chain holds one beat.
// Back-pressure ripples cell by cell, so bubbles are squeezed out.
// Reset is synchronous and clears all valid flags and the registers to
// their reset values.
`default_nettype none

module difficulty_retarget_core #(
   parameter int DIV_STEPS = drt_pkg::DIV_STEPS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_previous_compact,
   input  wire logic [29:0] req_elapsed_time,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_next_compact
);
   import drt_pkg::*;

   localparam int DIV_CELLS = WORD_BITS / DIV_STEPS;

   logic [INTERVAL_BITS-1:0] interval_ff;
   logic [63:0] limit3_ff, limit2_ff, limit1_ff, limit0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
         limit3_ff <= LIMIT3_RESET;
         limit2_ff <= LIMIT_LOW_RESET;
         limit1_ff <= LIMIT_LOW_RESET;
         limit0_ff <= LIMIT_LOW_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_INTERVAL: interval_ff <= csr_write_data[INTERVAL_BITS-1:0];
            CSR_LIMIT3: limit3_ff <= csr_write_data;
            CSR_LIMIT2: limit2_ff <= csr_write_data;
            CSR_LIMIT1: limit1_ff <= csr_write_data;
            CSR_LIMIT0: limit0_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Front stages: decode, clamp products, reciprocal divide, clamp.
   logic f1_valid_ff, f2_valid_ff, f3_valid_ff;
   logic f1_ready, f2_ready, f3_ready;
   logic [WORD_BITS-1:0] f1_word_ff, f2_word_ff, f3_word_ff, decoded;
   logic [30:0] f1_low_ff, f1_sum_ff;
   logic [31:0] f1_high_ff;
   logic [SPAN_BITS-1:0] f2_low_ff, f2_high_ff, f3_span_ff, f3_span_in;
   logic [28:0] f2_base_ff;
   logic [62:0] low_recip;
   logic [63:0] high_recip;

   always_comb begin
      logic [7:0] size;
      logic [7:0] up;
      logic [1:0] down;
      logic [WORD_BITS-1:0] mant;
      size = req_previous_compact[31:24];
      mant = {{(WORD_BITS-23){1'b0}}, req_previous_compact[22:0]};
      up = '0;
      down = '0;
      decoded = '0;
      if (size <= 8'd3) begin
         down = 2'(8'd3 - size);
         decoded = mant >> {down, 3'b000};
      end else begin
         up = size - 8'd3;
         if (up < 8'd32) begin
            decoded = mant << {up[4:0], 3'b000};
         end
      end
   end

   assign low_recip = 63'(f1_low_ff) * 63'(RECIP_HUNDRED);
   assign high_recip = 64'(f1_high_ff) * 64'(RECIP_HUNDRED);

   always_comb begin
      logic [SPAN_BITS-1:0] base;
      base = SPAN_BITS'(f2_base_ff);
      if (f2_base_ff < {4'd0, f2_low_ff}) begin
         f3_span_in = f2_low_ff;
      end else if (f2_base_ff > {4'd0, f2_high_ff}) begin
         f3_span_in = f2_high_ff;
      end else begin
         f3_span_in = base;
      end
   end

   logic div_ready0;
   assign f3_ready = !f3_valid_ff || div_ready0;
   assign f2_ready = !f2_valid_ff || f3_ready;
   assign f1_ready = !f1_valid_ff || f2_ready;
   assign req_ready = f1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else begin
         if (f1_ready) f1_valid_ff <= req_valid;
         if (f2_ready) f2_valid_ff <= f1_valid_ff;
         if (f3_ready) f3_valid_ff <= f2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (f1_ready && req_valid) begin
         f1_word_ff <= decoded;
         f1_low_ff <= 31'(interval_ff) * 31'(LOW_PERCENT);
         f1_high_ff <= 32'(interval_ff) * 32'(HIGH_PERCENT);
         f1_sum_ff <= 31'(interval_ff) * 31'(OLD_WEIGHT) + {1'b0, req_elapsed_time};
      end
      if (f2_ready && f1_valid_ff) begin
         f2_word_ff <= f1_word_ff;
         f2_low_ff <= low_recip[RECIP_SHIFT +: SPAN_BITS];
         f2_high_ff <= high_recip[RECIP_SHIFT +: SPAN_BITS];
         f2_base_ff <= f1_sum_ff[30:2];
      end
      if (f3_ready && f2_valid_ff) begin
         f3_word_ff <= f2_word_ff;
         f3_span_ff <= f3_span_in;
      end
   end

   // Divider chain.
   logic [DIV_CELLS:0] div_valid, div_ready;
   div_beat_type div_data [DIV_CELLS+1];

   assign div_valid[0] = f3_valid_ff;
   assign div_ready0 = div_ready[0];
   assign div_data[0] = '{word: f3_word_ff, rem: '0, span: f3_span_ff};

   for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
      drt_div_cell #(.STEPS(DIV_STEPS)) u_cell (
         .clock(clock),
         .reset(reset),
         .divisor(interval_ff),
         .in_valid(div_valid[g]),
         .in_ready(div_ready[g]),
         .in_data(div_data[g]),
         .out_valid(div_valid[g+1]),
         .out_ready(div_ready[g+1]),
         .out_data(div_data[g+1])
      );
   end

   // Multiplier chain.
   logic [LIMBS:0] mul_valid, mul_ready;
   mul_beat_type mul_data [LIMBS+1];

   assign mul_valid[0] = div_valid[DIV_CELLS];
   assign div_ready[DIV_CELLS] = mul_ready[0];
   assign mul_data[0] = '{word: div_data[DIV_CELLS].word, carry: '0,
                          span: div_data[DIV_CELLS].span};

   for (genvar g = 0; g < LIMBS; g++) begin : g_mul
      drt_mul_cell #(.LIMB(g)) u_cell (
         .clock(clock),
         .reset(reset),
         .in_valid(mul_valid[g]),
         .in_ready(mul_ready[g]),
         .in_data(mul_data[g]),
         .out_valid(mul_valid[g+1]),
         .out_ready(mul_ready[g+1]),
         .out_data(mul_data[g+1])
      );
   end

   drt_encode u_encode (
      .clock(clock),
      .reset(reset),
      .limit({limit3_ff, limit2_ff, limit1_ff, limit0_ff}),
      .in_valid(mul_valid[LIMBS]),
      .in_ready(mul_ready[LIMBS]),
      .in_word(mul_data[LIMBS].word),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .out_compact(rsp_next_compact)
   );

endmodule

`default_nettype wire

/* src/drt_checker.sv */
// ----------------------------------------------------------------------------
// Retarget port checker
// Watches the ports of the retarget core over time.
// ----------------------------------------------------------------------------
`default_nettype none

module drt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_next_compact
);

   // A result beat that is not taken stays put.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_next_compact))
      else $error("result beat changed while stalled");

   // The encoder never sets the sign bit.
   a_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !rsp_next_compact[23])
      else $error("sign bit set in result");

   // A 256-bit target never needs more than 33 size bytes.
   a_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_next_compact[31:24] <= 8'd33)
      else $error("size byte out of range");

   // Reset empties the pipeline.
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind difficulty_retarget_core drt_checker u_drt_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_next_compact(rsp_next_compact)
);

`default_nettype wire

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// Difficulty retarget testbench
// Drives compact difficulties and elapsed times into the retarget core under
// random idling and back-pressure, checks each result beat in order against
// the directed table or a prediction made with 256-bit arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import drt_pkg::*;

   localparam int DRAIN_CYCLES = 60;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 210;

   typedef struct packed {
      logic [31:0] prev;
      logic [29:0] used;
      logic        known;
      logic [31:0] want;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 17;
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{32'h0000_0000, 30'd0,          1'b1, 32'h0000_0000},
      '{32'h0480_0000, 30'd15000,      1'b1, 32'h0000_0000},
      '{32'hff7f_ffff, 30'd15000,      1'b1, 32'h0000_0000},
      '{32'hffff_ffff, 30'h3fff_ffff,  1'b1, 32'h0000_0000},
      '{32'h0012_3456, 30'd15000,      1'b1, 32'h0000_0000},
      '{32'h207f_ffff, 30'd15000,      1'b1, 32'h2000_ffff},
      '{32'h227f_ffff, 30'd15000,      1'b0, 32'h0},
      '{32'h1d00_ffff, 30'd15000,      1'b0, 32'h0},
      '{32'h1d00_ffff, 30'd0,          1'b0, 32'h0},
      '{32'h1d00_ffff, 30'h3fff_ffff,  1'b0, 32'h0},
      '{32'h1d80_ffff, 30'd15000,      1'b0, 32'h0},
      '{32'h0112_3456, 30'd15000,      1'b0, 32'h0},
      '{32'h0212_3456, 30'd15000,      1'b0, 32'h0},
      '{32'h0312_3456, 30'd15000,      1'b0, 32'h0},
      '{32'h037f_ffff, 30'd15000,      1'b0, 32'h0},
      '{32'h1e7f_ffff, 30'd11000,      1'b0, 32'h0},
      '{32'h1c12_3456, 30'd19000,      1'b0, 32'h0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = CSR_INTERVAL;
   logic [63:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_previous_compact = '0;
   logic [29:0] req_elapsed_time = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_next_compact;

   logic [23:0]  interval_copy;
   logic [255:0] limit_copy;
   logic [31:0]  next_compact_due [$];
   int           errors = 0;
   int           idle_pct = 0;
   bit           hold_request = 1'b0;
   int           quiet_cycles = 0;

   difficulty_retarget_core i_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_previous_compact (req_previous_compact),
      .req_elapsed_time     (req_elapsed_time),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_next_compact     (rsp_next_compact)
   );

   always #1 clock = ~clock;

   function automatic logic [31:0] retarget_compact(input logic [31:0] prev,
                                                    input logic [29:0] used);
      logic [63:0]  ti;
      logic [63:0]  lo;
      logic [63:0]  hi;
      logic [63:0]  span;
      logic [255:0] target;
      logic [255:0] shifted;
      logic [31:0]  low_word;
      logic [23:0]  mant;
      int           size_in;
      int           bits;
      int           size_out;
      ti = 64'(interval_copy);
      lo = (ti * 64'd84) / 64'd100;
      hi = (ti * 64'd132) / 64'd100;
      span = (ti * 64'd3 + 64'(used)) / 64'd4;
      if (span < lo) span = lo;
      if (span > hi) span = hi;

      // Decode: the sign bit is dropped and bits pushed past 256 are lost.
      size_in = int'(prev[31:24]);
      if (size_in <= 3) begin
         target = 256'(prev[22:0]) >> (8 * (3 - size_in));
      end else if (8 * (size_in - 3) < 256) begin
         target = 256'(prev[22:0]) << (8 * (size_in - 3));
      end else begin
         target = '0;
      end

      if (ti == 0) begin
         target = '0;
      end else begin
         target = target / 256'(ti);
      end
      target = target * 256'(span);
      if (target > limit_copy) target = limit_copy;

      bits = 0;
      for (int i = 255; i >= 0; i--) begin
         if (target[i]) begin
            bits = i + 1;
            break;
         end
      end
      size_out = (bits + 7) / 8;
      if (size_out <= 3) begin
         low_word = target[31:0] << (8 * (3 - size_out));
         mant = low_word[23:0];
      end else begin
         shifted = target >> (8 * (size_out - 3));
         mant = shifted[23:0];
      end
      // A set top mantissa bit would read as a sign, so move up one byte.
      if (mant[23]) begin
         mant = mant >> 8;
         size_out++;
      end
      return {size_out[7:0], 1'b0, mant[22:0]};
   endfunction

   task automatic csr_write(input logic [2:0] index, input logic [63:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      case (index)
         CSR_INTERVAL: interval_copy = data[23:0];
         CSR_LIMIT3: limit_copy[255:192] = data;
         CSR_LIMIT2: limit_copy[191:128] = data;
         CSR_LIMIT1: limit_copy[127:64] = data;
         CSR_LIMIT0: limit_copy[63:0] = data;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_drain();
      while (next_compact_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [23:0] ti, input logic [63:0] w3,
                                input logic [63:0] w2, input logic [63:0] w1,
                                input logic [63:0] w0);
      wait_drain();
      csr_write(CSR_INTERVAL, 64'(ti));
      csr_write(CSR_LIMIT3, w3);
      csr_write(CSR_LIMIT2, w2);
      csr_write(CSR_LIMIT1, w1);
      csr_write(CSR_LIMIT0, w0);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_beat(input logic [31:0] prev, input logic [29:0] used,
                            input logic known, input logic [31:0] want);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_previous_compact <= prev;
      req_elapsed_time <= used;
      do @(posedge clock); while (!req_ready);
      next_compact_due.push_back(known ? want : retarget_compact(prev, used));
   endtask

   function automatic logic [31:0] random_compact();
      logic [7:0] size_byte;
      case ($urandom_range(3))
         0: return $urandom;
         1: size_byte = 8'($urandom_range(0, 3));
         2: size_byte = 8'($urandom_range(0, 35));
         default: size_byte = 8'($urandom_range(23, 33));
      endcase
      return {size_byte, 24'($urandom)};
   endfunction

   function automatic logic [29:0] random_elapsed();
      int unsigned span_top;
      span_top = 4 * int'(interval_copy) + 4;
      if (span_top > 32'h3fff_ffff) span_top = 32'h3fff_ffff;
      case ($urandom_range(7))
         0: return 30'($urandom);
         1: return $urandom_range(1) ? 30'h3fff_ffff : 30'd0;
         default: return 30'($urandom_range(0, span_top));
      endcase
   endfunction

   function automatic logic [63:0] random_limit_word();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(3))
         0: return w >> $urandom_range(0, 63);
         1: return '0;
         default: return w;
      endcase
   endfunction

   // Receiver: random stall bursts, plus one long hold on request.
   initial begin
      forever begin
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (next_compact_due.size() == 0) begin
            $error("next_compact: unexpected beat, actual %h", rsp_next_compact);
            errors++;
         end else begin
            if (rsp_next_compact !== next_compact_due[0]) begin
               $error("next_compact: expected %h, actual %h",
                      next_compact_due[0], rsp_next_compact);
               errors++;
            end
            void'(next_compact_due.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_write_enable || (req_valid && req_ready) ||
          (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      logic [23:0] ti;
      interval_copy = INTERVAL_RESET;
      limit_copy = {LIMIT3_RESET, LIMIT_LOW_RESET, LIMIT_LOW_RESET, LIMIT_LOW_RESET};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_pct = 20;
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         send_beat(DIRECTED[r].prev, DIRECTED[r].used, DIRECTED[r].known,
                   DIRECTED[r].want);
      end
      req_valid <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: apply_setting(24'd1, '1, '1, '1, '1);
            1: apply_setting(24'hff_ffff, LIMIT3_RESET, '1, '1, '1);
            2: apply_setting(24'd0, random_limit_word(), '1, '1, '1);
            3: apply_setting(24'd15000, '0, '0, '0, '0);
            4: apply_setting(24'd600, LIMIT3_RESET, '1, '1, '1);
            default: begin
               ti = $urandom_range(1) ? 24'($urandom_range(1, 24'hff_ffff))
                                      : 24'($urandom_range(1, 2000));
               apply_setting(ti, random_limit_word(), random_limit_word(),
                             random_limit_word(), random_limit_word());
            end
         endcase
         // Phase one and the closing phase run without any idling.
         idle_pct = (p == 1 || p == PHASES - 1) ? 0 : 15 + 10 * (p % 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 4 && n == 50) hold_request = 1'b1;
            if (p == 5 && n == 100) begin
               req_valid <= 1'b0;
               wait_drain();
            end
            send_beat(random_compact(), random_elapsed(), 1'b0, 32'h0);
         end
         req_valid <= 1'b0;
      end

      wait_drain();
      if (errors == 0 && next_compact_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
src/drt_pkg.sv
src/drt_div_cell.sv
src/drt_mul_cell.sv
src/drt_encode.sv
src/difficulty_retarget_core.sv
src/drt_checker.sv
tb/sv/testbench.sv
